@@ hdl/sdt_pkg.sv @@
// ----------------------------------------------------------------------------
// Soft decision tree package
// Shared constants, operation codes and the exp and sigmoid lookup tables.
// ----------------------------------------------------------------------------
package sdt_pkg;

  localparam int unsigned SDT_NUM_FEATURES = 64;
  localparam int unsigned SDT_TREE_DEPTH   = 4;
  localparam int unsigned SDT_NUM_CLASSES  = 32;

  localparam int unsigned WEIGHT_DEPTH = 1024;
  localparam int unsigned WADDR_W      = 10;
  localparam int unsigned LEAF_DEPTH   = 512;
  localparam int unsigned LADDR_W      = 9;

  localparam int unsigned VAL_W   = 16;
  localparam int unsigned EXP_W   = 25;
  localparam int unsigned SIG_W   = 16;
  localparam int unsigned PI_W    = 17;
  localparam int unsigned MUL_W   = 18;
  localparam int unsigned CACC_W  = 24;
  localparam int unsigned CLASS_W = 6;

  localparam logic [63:0] EXP_STEP = 64'd4034748382;

  typedef enum logic [1:0] {
    OP_WEIGHT  = 2'd0,
    OP_LEAF    = 2'd1,
    OP_FEATURE = 2'd2
  } op_e;

  typedef logic [255:0][EXP_W-1:0] exp_tab_t;
  typedef logic [255:0][SIG_W-1:0] sig_tab_t;

  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] cur;
    cur = 64'd1 << 24;
    for (int i = 0; i < 256; i++) begin
      tab[i] = EXP_W'(cur);
      cur = (cur * EXP_STEP + 64'h8000_0000) >> 32;
    end
    return tab;
  endfunction

  function automatic sig_tab_t build_sig_tab();
    exp_tab_t    etab;
    sig_tab_t    tab;
    logic [63:0] den;
    logic [63:0] f;
    etab = build_exp_tab();
    for (int i = 0; i < 256; i++) begin
      if (i >= 128) begin
        den = (64'd1 << 24) + 64'(etab[i-128]);
      end else begin
        den = (64'd1 << 24) + 64'(etab[128-i]);
      end
      f = udiv64((64'd1 << 40) + (den >> 1), den);
      if (i >= 128) begin
        tab[i] = SIG_W'(f);
      end else begin
        tab[i] = SIG_W'(64'd65536 - f);
      end
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();
  localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

@@ hdl/sdt_in_if.sv @@
// ----------------------------------------------------------------------------
// Soft decision tree input channel
// Valid/ready channel carrying load and feature transactions.
// ----------------------------------------------------------------------------
interface sdt_in_if import sdt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [WADDR_W-1:0]      index;
  logic signed [VAL_W-1:0] value;
  logic                    last_feature;

  modport source (output valid, operation, index, value, last_feature, input ready);
  modport sink (input valid, operation, index, value, last_feature, output ready);
endinterface

@@ hdl/sdt_out_if.sv @@
// ----------------------------------------------------------------------------
// Soft decision tree output channel
// Valid/ready channel carrying one class probability per transaction.
// ----------------------------------------------------------------------------
interface sdt_out_if import sdt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] class_index;
  logic [SIG_W-1:0]   probability;
  logic               last;

  modport source (output valid, class_index, probability, last, input ready);
  modport sink (input valid, class_index, probability, last, output ready);
endinterface

@@ hdl/sdt_mul.sv @@
// ----------------------------------------------------------------------------
// Soft decision tree shared multiplier
// Signed multiplier, registered product, shared by dot, path and class steps.
// ----------------------------------------------------------------------------
module sdt_mul import sdt_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [MUL_W-1:0]   a_i,
  input  logic signed [MUL_W-1:0]   b_i,
  output logic signed [2*MUL_W-1:0] p_o
);
  logic signed [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;
endmodule

@@ hdl/sdt_div.sv @@
// ----------------------------------------------------------------------------
// Soft decision tree divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdt_div import sdt_pkg::*; #(
  parameter int unsigned DIV_W = 30
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DIV_W+PI_W-1:0]   dividend_i,
  input  logic [DIV_W-1:0]        divisor_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [PI_W-1:0]         quot_o
);
  localparam int unsigned DVD_W = DIV_W + PI_W;
  localparam int unsigned CNT_W = $clog2(PI_W);

  logic [DVD_W-1:0] rem_q;
  logic [DVD_W-2:0] dsh_q;
  logic [PI_W-1:0]  quot_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             ge;

  assign ge = rem_q >= {1'b0, dsh_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(PI_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsh_q  <= {divisor_i, {(PI_W-1){1'b0}}};
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - {1'b0, dsh_q};
      end
      quot_q <= {quot_q[PI_W-2:0], ge};
      dsh_q  <= dsh_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

@@ hdl/soft_decision_tree_infer.sv @@
// ----------------------------------------------------------------------------
// Soft decision tree inference
// Loads split weights and leaf scores, buffers features and on the last
// feature computes one probability per class with a shared multiplier and
// a serial divider under one sequencer.
//
//   Channel  Dir  Transaction
//   in_i     in   operation, index, value, last_feature
//   out_o    out  class_index, probability, last
//
// Loads and features are taken only while the sequencer is idle. An
// inference is paced by the shared multiplier and the one-bit-per-cycle
// divider in the softmax. After reset a clearing pass zeroes the weight
// and leaf stores; no transaction is accepted meanwhile. Input is not
// ready while an inference runs; a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module soft_decision_tree_infer import sdt_pkg::*; #(
  parameter int unsigned NUM_FEATURES = SDT_NUM_FEATURES,
  parameter int unsigned TREE_DEPTH   = SDT_TREE_DEPTH,
  parameter int unsigned NUM_CLASSES  = SDT_NUM_CLASSES
) (
  input logic       clk_i,
  input logic       rst_ni,
  sdt_in_if.sink    in_i,
  sdt_out_if.source out_o
);
  localparam int unsigned INNER_CNT   = (1 << TREE_DEPTH) - 1;
  localparam int unsigned LEAF_CNT    = 1 << TREE_DEPTH;
  localparam int unsigned ALL_NODES   = 2 * LEAF_CNT - 1;
  localparam int unsigned PP_W        = TREE_DEPTH + 1;
  localparam int unsigned FW          = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int unsigned CW          = $clog2(NUM_CLASSES);
  localparam int unsigned ACC_W       = 20 + $clog2(NUM_FEATURES);
  localparam int unsigned TOT_W       = EXP_W + CW;
  localparam int unsigned DVD_W       = TOT_W + PI_W;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(32768));

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DOT   = 4'd2;
  localparam logic [3:0] ST_SIG   = 4'd3;
  localparam logic [3:0] ST_ROOT  = 4'd4;
  localparam logic [3:0] ST_LMUL  = 4'd5;
  localparam logic [3:0] ST_LW    = 4'd6;
  localparam logic [3:0] ST_RW    = 4'd7;
  localparam logic [3:0] ST_LMU   = 4'd8;
  localparam logic [3:0] ST_MAX   = 4'd9;
  localparam logic [3:0] ST_SUM   = 4'd10;
  localparam logic [3:0] ST_PI    = 4'd11;
  localparam logic [3:0] ST_DIV   = 4'd12;
  localparam logic [3:0] ST_ACC   = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;
  localparam logic [3:0] ST_OWAIT = 4'd15;

  logic [3:0]              state_q, state_d;
  logic [1:0]              ph_q, ph_d;
  logic [WADDR_W-1:0]      clr_q, clr_d;
  logic [FW-1:0]           f_q, f_d;
  logic [TREE_DEPTH-1:0]   n_q, n_d;
  logic [TREE_DEPTH-1:0]   leaf_q, leaf_d;
  logic [CW-1:0]           c_q, c_d;
  logic [WADDR_W-1:0]      wbase_q, wbase_d;
  logic [LADDR_W-1:0]      lbase_q, lbase_d;
  logic                    out_valid_q, out_valid_d;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [SIG_W-1:0]        d_q, d_d;
  logic [SIG_W-1:0]        mu_q, mu_d;
  logic signed [VAL_W-1:0] max_q, max_d;
  logic [TOT_W-1:0]        tot_q, tot_d;
  logic [CLASS_W-1:0]      out_class_q, out_class_d;
  logic [SIG_W-1:0]        out_prob_q, out_prob_d;
  logic                    out_last_q, out_last_d;

  logic signed [VAL_W-1:0] weight_mem [WEIGHT_DEPTH];
  logic signed [VAL_W-1:0] leaf_mem [LEAF_DEPTH];
  logic signed [VAL_W-1:0] feat_mem [NUM_FEATURES];
  logic [SIG_W-1:0]        pp_mem [ALL_NODES];
  logic [CACC_W-1:0]       cacc_mem [NUM_CLASSES];

  logic signed [VAL_W-1:0] w_rd_q, l_rd_q, f_rd_q;
  logic [SIG_W-1:0]        pp_rd_q;
  logic [CACC_W-1:0]       ca_rd_q;

  logic                    w_we, l_we, feat_we, pp_we, ca_we;
  logic [WADDR_W-1:0]      w_waddr;
  logic [LADDR_W-1:0]      l_waddr;
  logic signed [VAL_W-1:0] w_wdata, l_wdata;
  logic [PP_W-1:0]         pp_waddr, pp_raddr;
  logic [SIG_W-1:0]        pp_wdata;
  logic [CACC_W-1:0]       ca_wdata;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic signed [23:0]        dot_term;
  logic [33:0]               rnd_sum;
  logic [SIG_W-1:0]          rnd;
  logic [VAL_W-1:0]          x_sat;
  logic [SIG_W-1:0]          sig_val;
  logic [PI_W-1:0]           comp_d;
  logic [VAL_W:0]            sdiff;
  logic [EXP_W-1:0]          e_cur;
  logic                      div_start, div_busy, div_done;
  logic [PI_W-1:0]           div_quot;
  logic [DVD_W-1:0]          div_dividend;
  logic                      in_fire;

  sdt_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  sdt_div #(
    .DIV_W (TOT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (tot_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign in_i.ready        = (state_q == ST_IDLE);
  assign in_fire           = in_i.valid && in_i.ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.class_index = out_class_q;
  assign out_o.probability = out_prob_q;
  assign out_o.last        = out_last_q;

  assign dot_term = mul_p[35:12];
  assign rnd_sum  = mul_p[33:0] + 34'd32768;
  assign rnd      = rnd_sum[31:16];
  assign comp_d   = 17'h10000 - {1'b0, d_q};
  assign sdiff    = {max_q[VAL_W-1], max_q} - {l_rd_q[VAL_W-1], l_rd_q};
  assign e_cur    = EXP_TAB[sdiff[15:8]];
  assign sig_val  = SIG_TAB[{~x_sat[15], x_sat[14:8]}];
  assign div_dividend = (DVD_W'(e_cur) << 16) + DVD_W'(tot_q >> 1);
  assign pp_raddr = (state_q == ST_LMU) ? (PP_W'(leaf_q) + PP_W'(INNER_CNT))
                                        : PP_W'(n_q);

  always_comb begin
    if (acc_q > SAT_HI) begin
      x_sat = 16'h7fff;
    end else if (acc_q < SAT_LO) begin
      x_sat = 16'h8000;
    end else begin
      x_sat = acc_q[15:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    clr_d       = clr_q;
    f_d         = f_q;
    n_d         = n_q;
    leaf_d      = leaf_q;
    c_d         = c_q;
    wbase_d     = wbase_q;
    lbase_d     = lbase_q;
    out_valid_d = out_valid_q;
    acc_d       = acc_q;
    d_d         = d_q;
    mu_d        = mu_q;
    max_d       = max_q;
    tot_d       = tot_q;
    out_class_d = out_class_q;
    out_prob_d  = out_prob_q;
    out_last_d  = out_last_q;
    w_we        = 1'b0;
    l_we        = 1'b0;
    feat_we     = 1'b0;
    pp_we       = 1'b0;
    ca_we       = 1'b0;
    w_waddr     = in_i.index;
    l_waddr     = in_i.index[LADDR_W-1:0];
    w_wdata     = in_i.value;
    l_wdata     = in_i.value;
    pp_waddr    = {n_q, 1'b1};
    pp_wdata    = rnd;
    ca_wdata    = ((leaf_q == '0) ? '0 : ca_rd_q) + CACC_W'(rnd);
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;

    unique case (state_q)
      ST_CLR: begin
        w_we    = 1'b1;
        l_we    = 1'b1;
        w_waddr = clr_q;
        l_waddr = clr_q[LADDR_W-1:0];
        w_wdata = '0;
        l_wdata = '0;
        clr_d   = clr_q + WADDR_W'(1);
        if (clr_q == WADDR_W'(WEIGHT_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_i.operation)
            OP_WEIGHT: w_we = 1'b1;
            OP_LEAF:   l_we = 1'b1;
            OP_FEATURE: begin
              feat_we = 32'(in_i.index) < NUM_FEATURES;
              if (in_i.last_feature) begin
                state_d = ST_DOT;
                ph_d    = 2'd0;
                f_d     = '0;
                n_d     = '0;
                wbase_d = '0;
                acc_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DOT: begin
        unique case (ph_q)
          2'd0: ph_d = 2'd1;
          2'd1: begin
            mul_a = MUL_W'(w_rd_q);
            mul_b = MUL_W'(f_rd_q);
            ph_d  = 2'd2;
          end
          default: begin
            acc_d = acc_q + ACC_W'(dot_term);
            ph_d  = 2'd0;
            if (f_q == FW'(NUM_FEATURES - 1)) begin
              state_d = ST_SIG;
            end else begin
              f_d = f_q + FW'(1);
            end
          end
        endcase
      end
      ST_SIG: begin
        d_d  = sig_val;
        ph_d = 2'd0;
        if (n_q == '0) begin
          state_d = ST_ROOT;
        end else begin
          state_d = ST_LMUL;
        end
      end
      ST_ROOT: begin
        pp_we = 1'b1;
        if (ph_q == 2'd0) begin
          pp_waddr = PP_W'(1);
          pp_wdata = d_q;
          ph_d     = 2'd1;
        end else begin
          pp_waddr = PP_W'(2);
          pp_wdata = comp_d[SIG_W-1:0];
          ph_d     = 2'd0;
          if (n_q == TREE_DEPTH'(INNER_CNT - 1)) begin
            state_d = ST_LMU;
            leaf_d  = '0;
            lbase_d = '0;
          end else begin
            state_d = ST_DOT;
            n_d     = n_q + TREE_DEPTH'(1);
            wbase_d = wbase_q + WADDR_W'(NUM_FEATURES);
            f_d     = '0;
            acc_d   = '0;
          end
        end
      end
      ST_LMUL: begin
        mu_d    = pp_rd_q;
        mul_a   = MUL_W'(d_q);
        mul_b   = MUL_W'(pp_rd_q);
        state_d = ST_LW;
      end
      ST_LW: begin
        pp_we   = 1'b1;
        mul_a   = MUL_W'(comp_d);
        mul_b   = MUL_W'(mu_q);
        state_d = ST_RW;
      end
      ST_RW: begin
        pp_we    = 1'b1;
        pp_waddr = {n_q, 1'b1} + PP_W'(1);
        ph_d     = 2'd0;
        if (n_q == TREE_DEPTH'(INNER_CNT - 1)) begin
          state_d = ST_LMU;
          leaf_d  = '0;
          lbase_d = '0;
        end else begin
          state_d = ST_DOT;
          n_d     = n_q + TREE_DEPTH'(1);
          wbase_d = wbase_q + WADDR_W'(NUM_FEATURES);
          f_d     = '0;
          acc_d   = '0;
        end
      end
      ST_LMU: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          mu_d    = pp_rd_q;
          max_d   = 16'sh8000;
          c_d     = '0;
          ph_d    = 2'd0;
          state_d = ST_MAX;
        end
      end
      ST_MAX: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          ph_d = 2'd0;
          if (l_rd_q > max_q) begin
            max_d = l_rd_q;
          end
          if (c_q == CW'(NUM_CLASSES - 1)) begin
            c_d     = '0;
            tot_d   = '0;
            state_d = ST_SUM;
          end else begin
            c_d = c_q + CW'(1);
          end
        end
      end
      ST_SUM: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          ph_d  = 2'd0;
          tot_d = tot_q + TOT_W'(e_cur);
          if (c_q == CW'(NUM_CLASSES - 1)) begin
            c_d     = '0;
            state_d = ST_PI;
          end else begin
            c_d = c_q + CW'(1);
          end
        end
      end
      ST_PI: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          ph_d      = 2'd0;
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mul_a   = MUL_W'(div_quot);
          mul_b   = MUL_W'(mu_q);
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        ca_we = 1'b1;
        ph_d  = 2'd0;
        if (c_q == CW'(NUM_CLASSES - 1)) begin
          c_d = '0;
          if (leaf_q == TREE_DEPTH'(LEAF_CNT - 1)) begin
            state_d = ST_OUT;
          end else begin
            leaf_d  = leaf_q + TREE_DEPTH'(1);
            lbase_d = lbase_q + LADDR_W'(NUM_CLASSES);
            state_d = ST_LMU;
          end
        end else begin
          c_d     = c_q + CW'(1);
          state_d = ST_PI;
        end
      end
      ST_OUT: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else begin
          ph_d        = 2'd0;
          out_valid_d = 1'b1;
          out_class_d = CLASS_W'(c_q);
          out_prob_d  = (ca_rd_q > CACC_W'(65535)) ? 16'hffff : ca_rd_q[SIG_W-1:0];
          out_last_d  = (c_q == CW'(NUM_CLASSES - 1));
          state_d     = ST_OWAIT;
        end
      end
      ST_OWAIT: begin
        if (out_o.ready) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = ST_IDLE;
          end else begin
            c_d     = c_q + CW'(1);
            state_d = ST_OUT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      ph_q        <= '0;
      clr_q       <= '0;
      f_q         <= '0;
      n_q         <= '0;
      leaf_q      <= '0;
      c_q         <= '0;
      wbase_q     <= '0;
      lbase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      clr_q       <= clr_d;
      f_q         <= f_d;
      n_q         <= n_d;
      leaf_q      <= leaf_d;
      c_q         <= c_d;
      wbase_q     <= wbase_d;
      lbase_q     <= lbase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    d_q         <= d_d;
    mu_q        <= mu_d;
    max_q       <= max_d;
    tot_q       <= tot_d;
    out_class_q <= out_class_d;
    out_prob_q  <= out_prob_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      weight_mem[w_waddr] <= w_wdata;
    end
    w_rd_q <= weight_mem[wbase_q + WADDR_W'(f_q)];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      leaf_mem[l_waddr] <= l_wdata;
    end
    l_rd_q <= leaf_mem[lbase_q + LADDR_W'(c_q)];
  end

  always_ff @(posedge clk_i) begin
    if (feat_we) begin
      feat_mem[in_i.index[FW-1:0]] <= in_i.value;
    end
    f_rd_q <= feat_mem[f_q];
  end

  always_ff @(posedge clk_i) begin
    if (pp_we) begin
      pp_mem[pp_waddr] <= pp_wdata;
    end
    pp_rd_q <= pp_mem[pp_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ca_we) begin
      cacc_mem[c_q] <= ca_wdata;
    end
    ca_rd_q <= cacc_mem[c_q];
  end

  // Input and output never overlap: results stream only after inference.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_valid_q))
    else $error("input ready while a result is pending");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_last_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (out_o.class_index == CLASS_W'(NUM_CLASSES - 1)))
    else $error("last flag on a class other than the final one");

  a_infer_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.operation == OP_FEATURE && in_i.last_feature) |=> (state_q == ST_DOT))
    else $error("last feature did not start inference");
endmodule

@@ tb/sv/sdt_infer_checker.sv @@
// ----------------------------------------------------------------------------
// Soft decision tree inference checker
// Watches both channels, keeps its own copy of the weight, leaf and feature
// stores, predicts the class probabilities of every inference and compares
// each output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module sdt_infer_checker import sdt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sdt_in_if    in_mon,
  sdt_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSPLIT = (1 << SDT_TREE_DEPTH) - 1;
  localparam int unsigned NLEAF  = 1 << SDT_TREE_DEPTH;

  typedef struct packed {
    logic [CLASS_W-1:0] class_index;
    logic [15:0]        probability;
    logic               last;
  } class_prob_t;

  logic signed [15:0] weight_mem [WEIGHT_DEPTH];
  logic signed [15:0] leaf_mem [LEAF_DEPTH];
  logic signed [15:0] feature_mem [SDT_NUM_FEATURES];
  longint unsigned    exp_lut [256];
  longint unsigned    sigmoid_lut [256];
  class_prob_t        expected_probs [$];
  int                 fails;

  assign fail_count_o = fails;

  function automatic longint unsigned logistic_of(longint unsigned e);
    longint unsigned den;
    den = (64'd1 << 24) + e;
    return ((64'd1 << 40) + den / 2) / den;
  endfunction

  initial begin
    fails     = 0;
    pending_o = 0;
    foreach (weight_mem[i]) weight_mem[i] = '0;
    foreach (leaf_mem[i]) leaf_mem[i] = '0;
    foreach (feature_mem[i]) feature_mem[i] = '0;
    exp_lut[0] = 64'd1 << 24;
    for (int i = 1; i < 256; i++) begin
      exp_lut[i] = (exp_lut[i-1] * 64'd4034748382 + 64'h8000_0000) >> 32;
    end
    for (int i = 0; i < 256; i++) begin
      if (i >= 128) begin
        sigmoid_lut[i] = logistic_of(exp_lut[i-128]);
      end else begin
        sigmoid_lut[i] = 65536 - logistic_of(exp_lut[128-i]);
      end
    end
  end

  function automatic longint unsigned node_decision(int unsigned node);
    int acc;
    int prod;
    acc = 0;
    for (int f = 0; f < SDT_NUM_FEATURES; f++) begin
      prod = int'(weight_mem[(node * SDT_NUM_FEATURES + f) % WEIGHT_DEPTH]) *
             int'(feature_mem[f]);
      acc += prod >>> 12;
    end
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return sigmoid_lut[(acc + 32768) >> 8];
  endfunction

  task automatic predict_classes();
    longint unsigned path [2*NLEAF-1];
    longint unsigned class_sum [SDT_NUM_CLASSES];
    longint unsigned e [SDT_NUM_CLASSES];
    longint unsigned d, mu, total, pi;
    int              m, s;
    class_prob_t     r;
    for (int n = 0; n < NSPLIT; n++) begin
      d = node_decision(n);
      if (n == 0) begin
        path[1] = d;
        path[2] = 65536 - d;
      end else begin
        path[2*n+1] = (d * path[n] + 32768) >> 16;
        path[2*n+2] = ((65536 - d) * path[n] + 32768) >> 16;
      end
    end
    foreach (class_sum[c]) class_sum[c] = 0;
    for (int lf = 0; lf < NLEAF; lf++) begin
      mu = path[lf + NSPLIT];
      m = -32768;
      total = 0;
      for (int c = 0; c < SDT_NUM_CLASSES; c++) begin
        s = leaf_mem[(lf * SDT_NUM_CLASSES + c) % LEAF_DEPTH];
        if (s > m) m = s;
      end
      for (int c = 0; c < SDT_NUM_CLASSES; c++) begin
        s = leaf_mem[(lf * SDT_NUM_CLASSES + c) % LEAF_DEPTH];
        e[c] = exp_lut[((m - s) >> 8) & 255];
        total += e[c];
      end
      if (total == 0) total = 1;
      for (int c = 0; c < SDT_NUM_CLASSES; c++) begin
        pi = ((e[c] << 16) + total / 2) / total;
        class_sum[c] = (class_sum[c] + ((pi * mu + 32768) >> 16)) & 64'hFF_FFFF;
      end
    end
    for (int c = 0; c < SDT_NUM_CLASSES; c++) begin
      r.class_index = CLASS_W'(c);
      r.probability = (class_sum[c] > 65535) ? 16'hFFFF : 16'(class_sum[c]);
      r.last        = (c == SDT_NUM_CLASSES - 1);
      expected_probs.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin
    class_prob_t want;
    if (rst_ni && in_mon.valid && in_mon.ready) begin
      case (in_mon.operation)
        OP_WEIGHT: weight_mem[in_mon.index] = in_mon.value;
        OP_LEAF: leaf_mem[in_mon.index % LEAF_DEPTH] = in_mon.value;
        OP_FEATURE: begin
          if (in_mon.index < SDT_NUM_FEATURES) feature_mem[in_mon.index] = in_mon.value;
          if (in_mon.last_feature) predict_classes();
        end
        default: ;
      endcase
    end
    if (rst_ni && out_mon.valid && out_mon.ready) begin
      if (expected_probs.size() == 0) begin
        fails++;
        $display("%0t: unexpected transaction class %0d probability %0d", $time,
                 out_mon.class_index, out_mon.probability);
      end else begin
        want = expected_probs.pop_front();
        if (out_mon.class_index !== want.class_index ||
            out_mon.probability !== want.probability || out_mon.last !== want.last) begin
          fails++;
          $display("%0t: expected class %0d prob %0d last %0d, got class %0d prob %0d last %0d",
                   $time, want.class_index, want.probability, want.last,
                   out_mon.class_index, out_mon.probability, out_mon.last);
        end
      end
    end
    pending_o = expected_probs.size();
  end

endmodule

@@ tb/sv/tb_soft_decision_tree_infer.sv @@
// ----------------------------------------------------------------------------
// Soft decision tree inference testbench
// Loads weights, leaf scores and features with directed corner values and
// then random load and inference sequences, under varying source and sink
// stalls, while the checker predicts and compares every class probability.
// ----------------------------------------------------------------------------
module tb_soft_decision_tree_infer import sdt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 20_000_000;

  logic clk_i;
  logic rst_ni;
  logic in_taken;
  int   fail_count;
  int   pending;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   cycles;

  sdt_in_if  in_if ();
  sdt_out_if out_if ();

  soft_decision_tree_infer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sdt_infer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) in_taken <= in_if.valid && in_if.ready;

  always @(negedge clk_i) out_if.ready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_soft_decision_tree_infer NOT OK");
      $finish;
    end
  end

  task automatic send(input op_e op, input int idx, input int val, input bit lastf);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= op;
    in_if.index        <= WADDR_W'(idx);
    in_if.value        <= VAL_W'(val);
    in_if.last_feature <= lastf;
    do @(negedge clk_i); while (!in_taken);
  endtask

  function automatic int rand_value();
    case ($urandom_range(3))
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(1024) - 512;
      2: return $urandom_range(8192) - 4096;
      default: return ($urandom_range(1) != 0) ? 32767 : -32768;
    endcase
  endfunction

  initial begin
    int r;
    cycles             = 0;
    in_taken           = 1'b0;
    tx_idle_pct        = 20;
    rx_idle_pct        = 78;
    in_if.valid        = 1'b0;
    in_if.operation    = OP_WEIGHT;
    in_if.index        = '0;
    in_if.value        = '0;
    in_if.last_feature = 1'b0;
    out_if.ready       = 1'b0;
    rst_ni             = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send(OP_WEIGHT, 0, 32767, 1'b1);
    send(OP_WEIGHT, 1023, -32768, 1'b0);
    send(OP_WEIGHT, 64, 4096, 1'b0);
    send(OP_LEAF, 0, 32767, 1'b1);
    send(OP_LEAF, 1, -32768, 1'b0);
    send(OP_LEAF, 511, 8000, 1'b0);
    send(OP_LEAF, 512 + 33, 12000, 1'b0);
    send(OP_LEAF, 1023, -3000, 1'b0);
    send(op_e'(2'd3), 1023, -1, 1'b1);
    for (int f = 0; f < SDT_NUM_FEATURES; f++) begin
      send(OP_FEATURE, f, (f % 2) ? -32768 : 32767, f == SDT_NUM_FEATURES - 1);
    end
    send(OP_FEATURE, 1023, 1234, 1'b1);
    send(OP_FEATURE, 5, 0, 1'b0);
    send(OP_FEATURE, 64, -7, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 78 : 0;
      rx_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 20 : 0;
      for (int k = 0; k < 35; k++) begin
        r = $urandom_range(99);
        if (r < 30) begin
          send(OP_WEIGHT, $urandom_range(1023), rand_value(), 1'($urandom_range(1)));
        end else if (r < 55) begin
          send(OP_LEAF, $urandom_range(1023), rand_value(), 1'($urandom_range(1)));
        end else if (r < 60) begin
          send(op_e'(2'd3), $urandom_range(1023), rand_value(), 1'($urandom_range(1)));
        end else begin
          send(OP_FEATURE, ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                  : $urandom_range(63),
               rand_value(), (k == 34) || ($urandom_range(39) == 0));
        end
      end
    end
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_soft_decision_tree_infer OK");
    end else begin
      $display("tb_soft_decision_tree_infer NOT OK");
    end
    $finish;
  end

endmodule
